// ===== rtl/core/project_and_rasterize_edge_macros.svh =====
// assertion macros shared by the checker
`ifndef PROJECT_AND_RASTERIZE_EDGE_MACROS_SVH
`define PROJECT_AND_RASTERIZE_EDGE_MACROS_SVH

// implication checked on every clock edge outside reset
`define PRE_ASSERT_IMP(label, clk_i, rst_i, pre, post) \
    label: assert property (@(posedge clk_i) disable iff (!rst_i) (pre) |-> (post)) \
        else $error("check failed");

// implication whose consequent is checked in the next cycle
`define PRE_ASSERT_NEXT(label, clk_i, rst_i, pre, post) \
    label: assert property (@(posedge clk_i) disable iff (!rst_i) (pre) |=> (post)) \
        else $error("check failed");

`endif

// ===== rtl/core/pre_pkg.sv =====
package pre_pkg;
    localparam int ScreenWidth  = 64;
    localparam int ScreenHeight = 32;
    localparam int RowAw        = $clog2(ScreenHeight);
    localparam int ColAw        = $clog2(ScreenWidth);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_COS  = 2'd0;
    localparam logic [1:0] REG_SIN  = 2'd1;
    localparam logic [1:0] REG_DIST = 2'd2;

    // screen coordinates carry 10 bits, saturated to -128..191
    typedef logic signed [9:0] coord_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_NEXTV,
        ST_LSETUP,
        ST_LDIV,
        ST_LRD,
        ST_LWR,
        ST_READ,
        ST_DONE
    } state_t;

    // unsigned restoring divider request
    typedef struct packed {
        logic        go;
        logic [47:0] num;
        logic [47:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } div_rsp_t;

    function automatic coord_t sat_coord(input logic signed [48:0] v);
        coord_t r;
        if (v < -49'sd128)
            r = -10'sd128;
        else if (v > 49'sd191)
            r = 10'sd191;
        else
            r = coord_t'(v);
        return r;
    endfunction
endpackage

// ===== rtl/core/project_and_rasterize_edge.sv =====
// channel  | ports                                         | handshake
// command  | operation, first_*/second_*, row_index        | start while !busy
// result   | row_pixels, edge_skipped                      | done strobe, 1 cycle
// config   | cfg_we, cfg_index, cfg_data                   | written when cfg_we
// after reset a clearing pass over all 32 rows (one row a cycle) holds busy high.
// clear zeroes all rows; read row registers the row at row_index into row_pixels.
// draw edge: two divisions per vertex through one shared 48-bit serial divider,
// then per pixel two more divisions plus a read-modify-write of the frame row,
// for s = max(|dx|, |dy|) pixels (a skipped edge ends early).
// results cannot be stalled; the block stays busy until its result strobe.
module project_and_rasterize_edge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic signed [15:0] first_x,
    input  logic signed [15:0] first_y,
    input  logic signed [15:0] first_z,
    input  logic signed [15:0] second_x,
    input  logic signed [15:0] second_y,
    input  logic signed [15:0] second_z,
    input  logic [4:0]         row_index,
    output logic               done,
    output logic [63:0]        row_pixels,
    output logic               edge_skipped,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import pre_pkg::*;

    state_t state_reg, state_next;

    logic signed [15:0] cos_reg, sin_reg;
    logic [14:0]        dist_reg;

    logic signed [15:0] vx_reg [2];
    logic signed [15:0] vy_reg [2];
    logic signed [15:0] vz_reg [2];
    logic               vsel_reg, vsel_next;
    logic               axis_reg, axis_next;

    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [47:0] rx_reg, ry_reg, d_reg;
    logic signed [47:0] d_sum;
    logic               neg_reg, neg_next;
    coord_t             sx_reg [2];
    coord_t             sy_reg [2];

    logic signed [10:0] dx_reg, dy_reg;
    logic [9:0]         s_reg;
    logic [9:0]         i_reg, i_next;
    coord_t             px_reg, py_reg;

    logic [RowAw:0]     cnt_reg, cnt_next;

    div_req_t           dreq;
    div_rsp_t           drsp;

    logic               ram_we;
    logic [RowAw-1:0]   ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;

    logic [63:0]        pix_reg, pix_next;
    logic               dflag_reg, dflag_next;
    logic               done_next;

    logic signed [47:0] num_s;
    logic signed [47:0] prod_s;
    logic signed [48:0] q_s;
    logic signed [10:0] lin_d;
    logic signed [20:0] lin_prod;
    logic signed [10:0] absx, absy;
    logic signed [10:0] ddx, ddy;
    logic               px_in;

    pre_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    pre_frame_ram u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg  <= 16'sd16384;
            sin_reg  <= '0;
            dist_reg <= 15'd12288;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COS:  cos_reg  <= cfg_data;
                REG_SIN:  sin_reg  <= cfg_data;
                REG_DIST: dist_reg <= cfg_data[14:0];
                default:  ;
            endcase
        end
    end

    // operands of the projection for the current vertex
    logic signed [15:0] cx, cy, cz;
    assign cx = vx_reg[vsel_reg];
    assign cy = vy_reg[vsel_reg];
    assign cz = vz_reg[vsel_reg];

    // depth of the current vertex, ready in the sum cycle
    assign d_sum = 48'(p3_reg) - 48'(p2_reg) + (48'(dist_reg) <<< 14);

    assign ddx = 11'(sx_reg[1]) - 11'(sx_reg[0]);
    assign ddy = 11'(sy_reg[1]) - 11'(sy_reg[0]);
    assign absx = ddx[10] ? -ddx : ddx;
    assign absy = ddy[10] ? -ddy : ddy;

    // numerator of the screen division: scale * (r + d), sign split off
    assign prod_s = axis_reg
        ? 48'((ry_reg + d_reg) <<< ColAw - (ColAw - RowAw))
        : 48'((rx_reg + d_reg) <<< ColAw);
    assign num_s  = prod_s;
    assign lin_d  = axis_reg ? dy_reg : dx_reg;
    assign lin_prod = lin_d * $signed({1'b0, i_reg});
    assign q_s = neg_reg ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
    assign px_in = !px_reg[9] && (px_reg < coord_t'(ScreenWidth))
                   && !py_reg[9] && (py_reg < coord_t'(ScreenHeight));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (cnt_reg == (RowAw+1)'(ScreenHeight - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (start)
                begin
                    case (operation)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_DRAW:  state_next = ST_MUL;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_DONE;
                    endcase
                end
            ST_CLEAR:
                if (cnt_reg == (RowAw+1)'(ScreenHeight - 1))
                    state_next = ST_DONE;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = (d_sum <= 0) ? ST_DONE : ST_DIV;
            ST_DIV:
                if (drsp.done && cnt_reg[0])
                    state_next = ST_NEXTV;
            ST_NEXTV: state_next = vsel_reg ? ST_LSETUP : ST_MUL;
            ST_LSETUP: state_next = ST_LDIV;
            ST_LDIV:
                if (i_reg >= s_reg)
                    state_next = ST_DONE;
                else if (drsp.done && axis_reg)
                    state_next = ST_LRD;
            ST_LRD:   state_next = ST_LWR;
            ST_LWR:   state_next = ST_LDIV;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        vsel_next  = vsel_reg;
        axis_next  = axis_reg;
        neg_next   = neg_reg;
        i_next     = i_reg;
        cnt_next   = cnt_reg;
        pix_next   = pix_reg;
        dflag_next = dflag_reg;
        done_next  = 1'b0;
        dreq       = '0;
        ram_we     = 1'b0;
        ram_waddr  = py_reg[RowAw-1:0];
        ram_wdata  = ram_rdata | (64'd1 << px_reg[ColAw-1:0]);
        ram_raddr  = py_reg[RowAw-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                vsel_next  = 1'b0;
                pix_next   = '0;
                dflag_next = 1'b0;
                cnt_next   = '0;
                ram_raddr  = row_index;
            end
            ST_INIT, ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[RowAw-1:0];
                ram_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_SUM:
            begin
                axis_next = 1'b0;
                cnt_next  = '0;
                if (d_sum <= 0)
                    dflag_next = 1'b1;
            end
            ST_DIV:
            begin
                if (cnt_reg[RowAw] == 1'b0)
                begin
                    dreq.go  = 1'b1;
                    dreq.num = num_s[47] ? 48'(-num_s) : num_s;
                    dreq.den = 48'(d_reg <<< 1);
                    neg_next = num_s[47];
                    cnt_next = {1'b1, {RowAw{1'b0}}} | {{RowAw{1'b0}}, cnt_reg[0]};
                end
                else if (drsp.done)
                begin
                    axis_next = 1'b1;
                    cnt_next  = {{RowAw{1'b0}}, 1'b1};
                end
            end
            ST_NEXTV:
                vsel_next = 1'b1;
            ST_LSETUP:
            begin
                i_next    = '0;
                axis_next = 1'b0;
                cnt_next  = '0;
            end
            ST_LDIV:
            begin
                if (i_reg < s_reg)
                begin
                    if (!cnt_reg[0])
                    begin
                        dreq.go  = 1'b1;
                        dreq.num = lin_prod[20] ? 48'(-lin_prod) : 48'(lin_prod);
                        dreq.den = 48'(s_reg);
                        neg_next = lin_prod[20];
                        cnt_next = {{RowAw{1'b0}}, 1'b1};
                    end
                    else if (drsp.done)
                    begin
                        cnt_next  = '0;
                        axis_next = ~axis_reg;
                    end
                end
            end
            ST_LRD:
            begin
                ram_raddr = py_reg[RowAw-1:0];
            end
            ST_LWR:
            begin
                ram_we = px_in;
                i_next = i_reg + 10'd1;
            end
            ST_READ:
                pix_next = ram_rdata;
            ST_DONE:
                done_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vsel_reg  <= vsel_next;
        axis_reg  <= axis_next;
        neg_reg   <= neg_next;
        i_reg     <= i_next;
        pix_reg   <= pix_next;
        dflag_reg <= dflag_next;
        if (state_reg == ST_IDLE && start)
        begin
            vx_reg[0] <= first_x;
            vy_reg[0] <= first_y;
            vz_reg[0] <= first_z;
            vx_reg[1] <= second_x;
            vy_reg[1] <= second_y;
            vz_reg[1] <= second_z;
        end
        if (state_reg == ST_MUL)
        begin
            p0_reg <= cx * cos_reg;
            p1_reg <= cz * sin_reg;
            p2_reg <= cx * sin_reg;
            p3_reg <= cz * cos_reg;
        end
        if (state_reg == ST_SUM)
        begin
            rx_reg <= 48'(p0_reg) + 48'(p1_reg);
            ry_reg <= 48'(cy) <<< 14;
            d_reg  <= d_sum;
        end
        if (state_reg == ST_DIV && cnt_reg[RowAw] && drsp.done)
        begin
            if (!axis_reg)
                sx_reg[vsel_reg] <= sat_coord(q_s);
            else
                sy_reg[vsel_reg] <= sat_coord(q_s);
        end
        if (state_reg == ST_LSETUP)
        begin
            dx_reg <= ddx;
            dy_reg <= ddy;
            s_reg  <= (absx > absy) ? 10'(absx) : 10'(absy);
        end
        if (state_reg == ST_LDIV && cnt_reg[0] && drsp.done)
        begin
            if (!axis_reg)
                px_reg <= sx_reg[0] + coord_t'(q_s);
            else
                py_reg <= sy_reg[0] + coord_t'(q_s);
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign row_pixels   = pix_reg;
    assign edge_skipped = dflag_reg;
endmodule

// ===== rtl/core/pre_divider.sv =====
module pre_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pre_pkg::div_req_t req,
    output pre_pkg::div_rsp_t rsp
);
    import pre_pkg::*;

    logic [47:0] quo_reg, quo_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [48:0] trial;

    // one quotient bit a cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[47]} - {1'b0, den_reg};
        if (req.go)
        begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = 6'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[48])
            begin
                rem_next = trial[47:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[46:0], quo_reg[47]};
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// ===== rtl/core/pre_frame_ram.sv =====
module pre_frame_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [pre_pkg::RowAw-1:0] waddr,
    input  logic [pre_pkg::ScreenWidth-1:0] wdata,
    input  logic [pre_pkg::RowAw-1:0] raddr,
    output logic [pre_pkg::ScreenWidth-1:0] rdata
);
    import pre_pkg::*;

    logic [ScreenWidth-1:0] mem [ScreenHeight];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/pre_checker.sv =====
module pre_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [63:0] row_pixels,
    input logic        edge_skipped
);
    `include "project_and_rasterize_edge_macros.svh"

    // an item is taken only when idle, so busy follows
    `PRE_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    // a result never comes while idle with no item pending
    `PRE_ASSERT_IMP(a_done_while_busy, clk, rst_n, done, $past(busy))
    // results are single-cycle strobes
    `PRE_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // skipped flag and pixels are never both set
    `PRE_ASSERT_IMP(a_excl, clk, rst_n, done && edge_skipped, row_pixels == 64'd0)
endmodule

bind project_and_rasterize_edge pre_checker u_pre_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .row_pixels  (row_pixels),
    .edge_skipped(edge_skipped)
);
